// ===== rtl/tbpf_pkg.sv =====
// Shared constants and types for the tile background pixel fetch block.
package tbpf_pkg;

    // Video memory geometry: bytes are stored in pairs, one 16-bit word per pair.
    localparam int VRAM_BYTES  = 8192;
    localparam int VRAM_ADDR_W = $clog2(VRAM_BYTES);
    localparam int VRAM_WORDS  = VRAM_BYTES / 2;
    localparam int WORD_ADDR_W = $clog2(VRAM_WORDS);

    // Tile map region: the upper two address bits of either map are set.
    localparam logic [1:0] MAP_REGION = 2'b11;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SCROLL_X    = 2'd0,
        CFG_SCROLL_Y    = 2'd1,
        CFG_MAP_SEL     = 2'd2,
        CFG_TILE_SEL    = 2'd3
    } t_cfg_index;

    // Item opcodes.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_PIXEL = 1'b1
    } t_opcode;

    // Port requests into the video memory.
    typedef struct packed {
        logic                   wr_en;
        logic [VRAM_ADDR_W-1:0] wr_addr;
        logic [7:0]             wr_data;
        logic                   map_rd_en;
        logic [WORD_ADDR_W-1:0] map_rd_addr;
        logic                   pat_rd_en;
        logic [WORD_ADDR_W-1:0] pat_rd_addr;
    } t_vram_req;

endpackage

// ===== rtl/tile_background_pixel_fetch.sv =====
// Top level of the tile background pixel fetch block.
//
// The block takes one item per cycle unless the input stalls. A write item
// stores a byte in the 8 KiB video memory and gives no result. The pixel path
// is a three-stage pipeline around one memory with two read ports: the first
// stage reads the tile map byte, the second reads the word that holds both bit
// planes of the tile row, the third selects the bit pair into the output
// register. The stages close up behind a stalled output, so the input stalls
// only when all of them are full. Reads see every write transferred before the
// pixel and none after it. The user must write configuration only while the
// block is idle; the block itself does not enforce it.
module tile_background_pixel_fetch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes.
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Input items.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [12:0] i_vram_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_screen_x,
    input  logic [7:0]  i_screen_y,
    // Results.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_color_index
);
    import tbpf_pkg::*;

    logic [7:0]  r_scroll_x;
    logic [7:0]  r_scroll_y;
    logic        r_map_sel;
    logic        r_tile_sel;

    logic        r_v1;
    logic [2:0]  r_row1;
    logic [2:0]  r_col1;
    logic        r_hi_byte1;
    logic        r_v2;
    logic [2:0]  r_col2;
    logic        r_out_valid;
    logic [1:0]  r_color;

    logic        en_out;
    logic        en2;
    logic        en1;
    logic        in_xfer;
    logic [7:0]  bg_x;
    logic [7:0]  bg_y;
    logic [7:0]  tile_num;
    logic [8:0]  tile_base;
    logic [15:0] map_word_q;
    logic [15:0] pat_word;
    logic [2:0]  bit_pos;
    t_vram_req   vram_req;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= '0;
            r_scroll_y <= '0;
            r_map_sel  <= 1'b0;
            r_tile_sel <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SCROLL_X: r_scroll_x <= i_cfg_data;
                CFG_SCROLL_Y: r_scroll_y <= i_cfg_data;
                CFG_MAP_SEL:  r_map_sel  <= i_cfg_data[0];
                CFG_TILE_SEL: r_tile_sel <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage enables: each stage loads when it is empty or the one after it moves.
    assign en_out     = !r_out_valid || !i_out_stall;
    assign en2        = !r_v2 || en_out;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;
    assign in_xfer    = i_in_valid && en1;

    // Background coordinate, wrapping at 256.
    assign bg_x = i_screen_x + r_scroll_x;
    assign bg_y = i_screen_y + r_scroll_y;

    // Tile number from the map byte; signed numbering is centered on 0x1000.
    assign tile_num  = r_hi_byte1 ? map_word_q[15:8] : map_word_q[7:0];
    assign tile_base = r_tile_sel ? {1'b0, tile_num} : {~tile_num[7], tile_num};

    // Memory requests.
    always_comb begin
        vram_req.wr_en       = in_xfer && (t_opcode'(i_opcode) == OP_WRITE);
        vram_req.wr_addr     = i_vram_address;
        vram_req.wr_data     = i_write_data;
        vram_req.map_rd_en   = in_xfer && (t_opcode'(i_opcode) == OP_PIXEL);
        vram_req.map_rd_addr = {MAP_REGION, r_map_sel, bg_y[7:3], bg_x[7:4]};
        vram_req.pat_rd_en   = en2 && r_v1;
        vram_req.pat_rd_addr = {tile_base, r_row1};
    end

    tbpf_vram u_vram (
        .i_clk      (i_clk),
        .i_req      (vram_req),
        .o_map_word (map_word_q),
        .o_pat_word (pat_word)
    );

    // Pipeline valid bits and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= in_xfer && (t_opcode'(i_opcode) == OP_PIXEL);
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en_out) begin
                r_out_valid <= r_v2;
            end
        end
    end

    // Per-stage payload.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_row1     <= bg_y[2:0];
            r_col1     <= bg_x[2:0];
            r_hi_byte1 <= bg_x[3];
        end
        if (en2) begin
            r_col2 <= r_col1;
        end
        if (en_out && r_v2) begin
            r_color <= {pat_word[8 + 32'(bit_pos)], pat_word[bit_pos]};
        end
    end

    // The leftmost pixel of a row is the most significant bit of each plane.
    assign bit_pos = 3'd7 - r_col2;

    assign o_out_valid   = r_out_valid;
    assign o_color_index = r_color;

endmodule

// ===== rtl/tbpf_vram.sv =====
// Video memory: 4096 words of two bytes, one byte write port and two word read ports.
module tbpf_vram (
    input  logic                          i_clk,
    input  tbpf_pkg::t_vram_req           i_req,
    output logic [15:0]                   o_map_word,
    output logic [15:0]                   o_pat_word
);
    import tbpf_pkg::*;

    logic [15:0] r_mem [VRAM_WORDS];
    logic [15:0] r_map_word;
    logic [15:0] r_pat_word;

    // Byte write: an even address lands in the low byte, an odd one in the high byte.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            if (i_req.wr_addr[0]) begin
                r_mem[i_req.wr_addr[VRAM_ADDR_W-1:1]][15:8] <= i_req.wr_data;
            end else begin
                r_mem[i_req.wr_addr[VRAM_ADDR_W-1:1]][7:0] <= i_req.wr_data;
            end
        end
    end

    // Registered reads; a read at the same edge as a write returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_req.map_rd_en) begin
            r_map_word <= r_mem[i_req.map_rd_addr];
        end
        if (i_req.pat_rd_en) begin
            r_pat_word <= r_mem[i_req.pat_rd_addr];
        end
    end

    assign o_map_word = r_map_word;
    assign o_pat_word = r_pat_word;

endmodule

// ===== rtl/tbpf_checker.sv =====
// Port-level checks for the tile background pixel fetch block, bound to the top level.
module tbpf_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_color_index
);

    // Reset empties the output register.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The input stalls only behind a full pipeline whose output is blocked.
    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output can move");

    // A stalled result stays offered.
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_color_index))
        else $error("result changed while stalled");

endmodule

bind tile_background_pixel_fetch tbpf_port_checks u_tbpf_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_color_index (o_color_index)
);

// ===== bench/tbpf_checker.sv =====
// Checker for the tile background pixel fetch block: colour prediction and result comparison.
`timescale 1ns / 1ps

module tbpf_checker
    import tbpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_opcode,
    input  logic [12:0] i_vram_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_screen_x,
    input  logic [7:0]  i_screen_y,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_color_index,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [12:0] MAP0_BASE   = 13'h1800;
    localparam logic [12:0] MAP1_BASE   = 13'h1C00;
    localparam logic [12:0] SIGNED_BASE = 13'h1000;

    // Private copy of the video memory and the background registers.
    logic [7:0] vram_copy [VRAM_BYTES];
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic       map1_selected;
    logic       unsigned_tiles;

    // Colours owed by the block, oldest first.
    logic [1:0] owed_colors [$];
    int         fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Works out the colour index of one screen pixel from the copy above.
    function automatic logic [1:0] predict_color(logic [7:0] sx, logic [7:0] sy);
        logic [7:0]  bx;
        logic [7:0]  by;
        logic [7:0]  tile;
        logic [12:0] map_addr;
        logic [12:0] tile_base;
        logic [12:0] row_lo;
        logic [12:0] row_hi;
        logic [2:0]  bit_pos;
        bx       = sx + scroll_x;
        by       = sy + scroll_y;
        map_addr = (map1_selected ? MAP1_BASE : MAP0_BASE) + {3'b000, by[7:3], bx[7:3]};
        tile     = vram_copy[map_addr];
        // Signed tile numbers count sixteen-byte tiles away from the signed base.
        if (unsigned_tiles) begin
            tile_base = {1'b0, tile, 4'b0000};
        end else begin
            tile_base = SIGNED_BASE + ({{5{tile[7]}}, tile} << 4);
        end
        row_lo  = tile_base + {9'b0, by[2:0], 1'b0};
        row_hi  = row_lo + 13'd1;
        bit_pos = 3'd7 - bx[2:0];
        return {vram_copy[row_hi][bit_pos], vram_copy[row_lo][bit_pos]};
    endfunction

    // Follow every register write and transfer at the clock edge.
    always @(posedge i_clk) begin
        logic [1:0] expected;
        if (!i_rst_n) begin
            scroll_x       = 8'd0;
            scroll_y       = 8'd0;
            map1_selected  = 1'b0;
            unsigned_tiles = 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SCROLL_X: scroll_x       = i_cfg_data;
                    CFG_SCROLL_Y: scroll_y       = i_cfg_data;
                    CFG_MAP_SEL:  map1_selected  = i_cfg_data[0];
                    CFG_TILE_SEL: unsigned_tiles = i_cfg_data[0];
                    default: ;
                endcase
            end

            // An input transfer either stores a byte or owes one colour.
            if (i_in_valid && !i_in_stall) begin
                if (i_opcode == OP_WRITE) begin
                    vram_copy[i_vram_address] = i_write_data;
                end else begin
                    owed_colors.push_back(predict_color(i_screen_x, i_screen_y));
                end
            end

            // An output transfer settles the oldest owed colour.
            if (i_out_valid && !i_out_stall) begin
                if (owed_colors.size() == 0) begin
                    $error("color_index: no result expected, actual %0d", i_color_index);
                    fails++;
                end else begin
                    expected = owed_colors.pop_front();
                    if (i_color_index !== expected) begin
                        $error("color_index mismatch: expected %0d, actual %0d",
                               expected, i_color_index);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= owed_colors.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/testbench.sv =====
// Testbench top for the tile background pixel fetch block: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module testbench;
    import tbpf_pkg::*;

    localparam int          ITEM_TARGET   = 1800;
    localparam int          PHASES        = 8;
    localparam int          SETTLE_CYCLES = 5;
    localparam int          QUIET_LIMIT   = 1000;
    localparam logic [12:0] MAP0_BASE     = 13'h1800;
    localparam logic [12:0] MAP1_BASE     = 13'h1C00;
    localparam logic [12:0] SIGNED_BASE   = 13'h1000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [1:0]  cfg_index    = CFG_SCROLL_X;
    logic [7:0]  cfg_data     = 8'd0;
    logic        in_valid     = 1'b0;
    logic        opcode       = OP_WRITE;
    logic [12:0] vram_address = 13'd0;
    logic [7:0]  write_data   = 8'd0;
    logic [7:0]  screen_x     = 8'd0;
    logic [7:0]  screen_y     = 8'd0;
    logic        out_stall    = 1'b0;
    wire         in_stall;
    wire         out_valid;
    wire  [1:0]  color_index;
    int          fail_count;
    int          pending;

    // Settings in force, kept so that pixel requests only touch written bytes.
    logic [7:0] cur_scroll_x   = 8'd0;
    logic [7:0] cur_scroll_y   = 8'd0;
    logic       cur_map1       = 1'b0;
    logic       cur_unsigned   = 1'b1;
    logic [7:0] vram_image   [VRAM_BYTES];
    bit         vram_written [VRAM_BYTES];

    bit idling      = 1'b1;
    int items_sent  = 0;
    int stall_left  = 0;
    int quiet_count = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    tile_background_pixel_fetch dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_vram_address (vram_address),
        .i_write_data   (write_data),
        .i_screen_x     (screen_x),
        .i_screen_y     (screen_y),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_color_index  (color_index)
    );

    tbpf_checker color_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_vram_address (vram_address),
        .i_write_data   (write_data),
        .i_screen_x     (screen_x),
        .i_screen_y     (screen_y),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_color_index  (color_index),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Output stall comes in bursts of random length while idling is on.
    always @(posedge clk) begin
        if (stall_left == 0 && idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19);
        end
        out_stall <= (stall_left != 0);
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // Offers one item, after a random gap while idling is on, and holds it until the block takes the transfer.
    task automatic send_item(t_opcode op, logic [12:0] addr, logic [7:0] data,
                             logic [7:0] sx, logic [7:0] sy);
        if (idling && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        vram_address <= addr;
        write_data   <= data;
        screen_x     <= sx;
        screen_y     <= sy;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (op == OP_WRITE) begin
            vram_image[addr]   = data;
            vram_written[addr] = 1'b1;
        end
        items_sent++;
    endtask

    task automatic send_write(logic [12:0] addr, logic [7:0] data);
        send_item(OP_WRITE, addr, data, 8'($urandom), 8'($urandom));
    endtask

    // Requests one pixel, first writing any map or pattern byte it would read unwritten.
    task automatic request_pixel(logic [7:0] sx, logic [7:0] sy);
        logic [7:0]  bx;
        logic [7:0]  by;
        logic [7:0]  tile;
        logic [12:0] map_addr;
        logic [12:0] row_lo;
        logic [12:0] row_hi;
        bx       = sx + cur_scroll_x;
        by       = sy + cur_scroll_y;
        map_addr = (cur_map1 ? MAP1_BASE : MAP0_BASE) + {3'b000, by[7:3], bx[7:3]};
        if (!vram_written[map_addr]) begin
            send_write(map_addr, 8'($urandom));
        end
        tile = vram_image[map_addr];
        if (cur_unsigned) begin
            row_lo = {1'b0, tile, 4'b0000};
        end else begin
            row_lo = SIGNED_BASE + ({{5{tile[7]}}, tile} << 4);
        end
        row_lo = row_lo + {9'b0, by[2:0], 1'b0};
        row_hi = row_lo + 13'd1;
        if (!vram_written[row_lo]) begin
            send_write(row_lo, 8'($urandom));
        end
        if (!vram_written[row_hi]) begin
            send_write(row_hi, 8'($urandom));
        end
        send_item(OP_PIXEL, 13'($urandom), 8'($urandom), sx, sy);
    endtask

    task automatic write_register(t_cfg_index idx, logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Writes all four background registers; the one-bit ones get random upper bits.
    task automatic apply_settings(logic [7:0] sx, logic [7:0] sy, logic map1,
                                  logic unsigned_tiles);
        write_register(CFG_SCROLL_X, sx);
        write_register(CFG_SCROLL_Y, sy);
        write_register(CFG_MAP_SEL, {7'($urandom), map1});
        write_register(CFG_TILE_SEL, {7'($urandom), unsigned_tiles});
        cfg_wr_en    <= 1'b0;
        cur_scroll_x = sx;
        cur_scroll_y = sy;
        cur_map1     = map1;
        cur_unsigned = unsigned_tiles;
    endtask

    // Drops valid and waits until every owed colour has come out and the pipe is empty.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        int         phase_end;
        int         pick;
        int         run_len;
        logic [7:0] px;
        logic [7:0] py;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with reset settings: the highest unsigned tile, both ends of a
        // pattern byte, the last memory byte, the largest and the last visible coordinates.
        send_write(13'h1800, 8'hFF);
        send_write(13'h0FF0, 8'hA5);
        send_write(13'h0FF1, 8'h3C);
        request_pixel(8'd0, 8'd0);
        request_pixel(8'd7, 8'd0);
        send_write(13'h1FFF, 8'h80);
        request_pixel(8'd255, 8'd255);
        request_pixel(8'd159, 8'd143);

        // Directed part with the opposite extremes: full scroll wraps the sum at 256,
        // the second map, and signed tiles at -128, 127 and 0.
        wait_idle();
        apply_settings(8'd255, 8'd255, 1'b1, 1'b0);
        request_pixel(8'd1, 8'd1);
        request_pixel(8'd0, 8'd0);
        send_write(13'h1C01, 8'h7F);
        request_pixel(8'd9, 8'd1);
        send_write(13'h1C02, 8'h00);
        request_pixel(8'd17, 8'd1);
        request_pixel(8'd200, 8'd250);

        // Random phases, each under its own settings; the last one runs without idling.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            if (phase == 0) begin
                idling = 1'b1;
            end else if (phase == PHASES - 1) begin
                idling = 1'b0;
            end else begin
                idling = ($urandom_range(0, 2) != 0);
            end
            case (phase)
                0:       apply_settings(8'd0, 8'd0, 1'b0, 1'b1);
                1:       apply_settings(8'd255, 8'd255, 1'b1, 1'b0);
                default: apply_settings(8'($urandom), 8'($urandom), 1'($urandom),
                                        1'($urandom));
            endcase
            phase_end = items_sent + ITEM_TARGET / PHASES;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    // Stray write anywhere in video memory.
                    send_write(13'($urandom), 8'($urandom));
                end else if (pick < 35) begin
                    // Retile one cell of the map in use.
                    send_write((cur_map1 ? MAP1_BASE : MAP0_BASE) + 13'($urandom_range(0, 1023)),
                               8'($urandom));
                end else if (pick < 45) begin
                    // A run of neighboring pixels along one line.
                    px      = 8'($urandom);
                    py      = 8'($urandom_range(0, 143));
                    run_len = $urandom_range(8, 16);
                    for (int k = 0; k < run_len; k++) begin
                        request_pixel(px + 8'(k), py);
                    end
                end else if (pick < 85) begin
                    request_pixel(8'($urandom_range(0, 159)), 8'($urandom_range(0, 143)));
                end else begin
                    request_pixel(8'($urandom), 8'($urandom));
                end
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
